FILE: design/mst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_pkg: shared types and constants of the Morse speed tracker
// Reset values, run limits, field widths and the cell control group.
// ----------------------------------------------------------------------------
package mst_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF = 8;
	localparam int unsigned COUNT_WIDTH_DEF   = 16;

	localparam int unsigned DURATION_W = 16;
	localparam int unsigned REF_TIME_W = 12;
	localparam int unsigned REF_SHIFT  = 4;

	localparam int unsigned DIT_INIT  = 32;
	localparam int unsigned DASH_INIT = 192;

	localparam int unsigned DIT_RUN_W  = 4;
	localparam int unsigned DASH_RUN_W = 3;

	localparam logic [DIT_RUN_W-1:0]  DIT_RUN_LIMIT    = 4'd15;
	localparam logic [DIT_RUN_W-1:0]  DIT_RUN_RESTART  = 4'd8;
	localparam logic [DASH_RUN_W-1:0] DASH_RUN_LIMIT   = 3'd7;
	localparam logic [DASH_RUN_W-1:0] DASH_RUN_RESTART = 3'd4;

	// control broadcast to every history cell of one chain
	typedef struct packed {
		logic shift;
		logic halve;
		logic dbl;
	} mst_cell_ctl_t;

endpackage

FILE: design/mst_element_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_element_if: input channel of the Morse speed tracker
// One item per measured element: dash flag and duration.
// ----------------------------------------------------------------------------
interface mst_element_if;
	logic                               valid;
	logic                               ready;
	logic                               is_dash;
	logic [mst_pkg::DURATION_W-1:0]     duration;

	modport source (output valid, output is_dash, output duration, input ready);
	modport sink   (input valid, input is_dash, input duration, output ready);
endinterface

FILE: design/mst_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_result_if: result channel of the Morse speed tracker
// One item per accepted element: the current reference time.
// ----------------------------------------------------------------------------
interface mst_result_if;
	logic                               valid;
	logic                               ready;
	logic [mst_pkg::REF_TIME_W-1:0]     reference_time;

	modport source (output valid, output reference_time, input ready);
	modport sink   (input valid, input reference_time, output ready);
endinterface

FILE: design/mst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_cell: one history entry
// Shift takes prev (neighbour or new duration); then optional halve or double.
// ----------------------------------------------------------------------------
module mst_cell #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned INIT  = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mst_pkg::mst_cell_ctl_t ctl,
	input  logic [WIDTH-1:0]      prev,
	output logic [WIDTH-1:0]      entry
);
	import mst_pkg::*;

	logic [WIDTH-1:0] entry_q;
	logic [WIDTH-1:0] base;
	logic [WIDTH-1:0] entry_d;

	always_comb begin
		base = ctl.shift ? prev : entry_q;
		if (ctl.halve) begin
			entry_d = base >> 1;
		end else if (ctl.dbl) begin
			entry_d = base << 1;
		end else begin
			entry_d = base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= WIDTH'(INIT);
		end else begin
			entry_q <= entry_d;
		end
	end

	assign entry = entry_q;

endmodule

FILE: design/mst_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_out_buf: two-entry result buffer
// Output register plus skid entry, so input takes one more item during a stall.
// ----------------------------------------------------------------------------
module mst_out_buf (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic [mst_pkg::REF_TIME_W-1:0]  push_data,
	output logic                            space,
	mst_result_if.source                    result
);
	import mst_pkg::*;

	logic                  head_valid_q;
	logic                  skid_valid_q;
	logic [REF_TIME_W-1:0] head_q;
	logic [REF_TIME_W-1:0] skid_q;
	logic                  pop;

	assign pop   = head_valid_q && result.ready;
	assign space = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				// full: no push possible
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (head_valid_q) begin
				if (push && !pop) begin
					skid_valid_q <= 1'b1;
				end else if (!push && pop) begin
					head_valid_q <= 1'b0;
				end
			end else if (push) begin
				head_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				head_q <= skid_q;
			end
		end else if (head_valid_q) begin
			if (push && pop) begin
				head_q <= push_data;
			end else if (push) begin
				skid_q <= push_data;
			end
		end else if (push) begin
			head_q <= push_data;
		end
	end

	assign result.valid          = head_valid_q;
	assign result.reference_time = head_q;

endmodule

FILE: design/morse_speed_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_speed_tracker: adaptive dit/dash reference-time estimator
// Two rows of history cells, running totals, run counters and dash rescale.
// ----------------------------------------------------------------------------
// Result: an accepted item's reference time is registered in the result buffer
// behind any earlier results. Throughput: one item per cycle while the buffer
// has space; all updates and the rescale of the dash row happen in the accepting
// cycle. The two-entry buffer keeps input open for one extra item in a stall.
// Reset: asynchronous; histories, totals, run counters and buffer cleared to
// their initial values at once, no clearing pass.
module morse_speed_tracker #(
	parameter int unsigned HISTORY_DEPTH = mst_pkg::HISTORY_DEPTH_DEF,
	parameter int unsigned COUNT_WIDTH   = mst_pkg::COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mst_element_if.sink   element,
	mst_result_if.source  result
);
	import mst_pkg::*;

	localparam int unsigned CW = COUNT_WIDTH;

	localparam logic [CW-1:0] DIT_TOTAL_INIT  = CW'(DIT_INIT * HISTORY_DEPTH);
	localparam logic [CW-1:0] DASH_TOTAL_INIT = CW'(DASH_INIT * HISTORY_DEPTH);

	logic                  acc;
	logic                  space;
	logic [CW-1:0]         dur;

	logic [CW-1:0]         dit_row  [HISTORY_DEPTH];
	logic [CW-1:0]         dash_row [HISTORY_DEPTH];
	mst_cell_ctl_t         dit_ctl;
	mst_cell_ctl_t         dash_ctl;

	logic [CW-1:0]         dit_total_q,  dit_total_d;
	logic [CW-1:0]         dash_total_q, dash_total_d, dash_sum;
	logic [DIT_RUN_W-1:0]  dit_run_q,  dit_run_pre,  dit_run_d;
	logic [DASH_RUN_W-1:0] dash_run_q, dash_run_pre, dash_run_d;
	logic                  halve, dbl;

	logic [CW-1:0]               total;
	logic [CW-1:0]               total_sh;
	logic [CW+REF_TIME_W-1:0]    total_ext;
	logic [REF_TIME_W-1:0]       ref_time;

	assign element.ready = space;
	assign acc = element.valid && space;

	// duration taken modulo 2^COUNT_WIDTH
	always_comb begin
		logic [CW+DURATION_W-1:0] dur_ext;
		dur_ext = {{CW{1'b0}}, element.duration};
		dur = dur_ext[CW-1:0];
	end

	always_comb begin
		if (element.is_dash) begin
			dit_run_pre  = '0;
			dash_run_pre = (dash_run_q < DASH_RUN_LIMIT) ? dash_run_q + 1'b1 : dash_run_q;
		end else begin
			dash_run_pre = '0;
			dit_run_pre  = (dit_run_q < DIT_RUN_LIMIT) ? dit_run_q + 1'b1 : dit_run_q;
		end
		halve = (dit_run_pre == DIT_RUN_LIMIT);
		dbl   = !halve && (dash_run_pre == DASH_RUN_LIMIT);
		dit_run_d  = halve ? DIT_RUN_RESTART : dit_run_pre;
		dash_run_d = dbl ? DASH_RUN_RESTART : dash_run_pre;

		// oldest entry sits at the far end of each row
		if (element.is_dash) begin
			dash_sum    = dash_total_q - dash_row[HISTORY_DEPTH-1] + dur;
			dit_total_d = dit_total_q;
		end else begin
			dash_sum    = dash_total_q;
			dit_total_d = dit_total_q - dit_row[HISTORY_DEPTH-1] + dur;
		end
		if (halve) begin
			dash_total_d = dash_sum >> 1;
		end else if (dbl) begin
			dash_total_d = dash_sum << 1;
		end else begin
			dash_total_d = dash_sum;
		end

		total     = dit_total_d + dash_total_d;
		total_sh  = total >> REF_SHIFT;
		total_ext = {{REF_TIME_W{1'b0}}, total_sh};
		ref_time  = total_ext[REF_TIME_W-1:0];
	end

	assign dit_ctl  = '{shift: acc && !element.is_dash, halve: 1'b0, dbl: 1'b0};
	assign dash_ctl = '{shift: acc && element.is_dash, halve: acc && halve, dbl: acc && dbl};

	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cells
		logic [CW-1:0] dit_prev;
		logic [CW-1:0] dash_prev;
		if (i == 0) begin : g_head
			assign dit_prev  = dur;
			assign dash_prev = dur;
		end else begin : g_link
			assign dit_prev  = dit_row[i-1];
			assign dash_prev = dash_row[i-1];
		end

		mst_cell #(.WIDTH(CW), .INIT(DIT_INIT)) u_dit_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (dit_ctl),
			.prev   (dit_prev),
			.entry  (dit_row[i])
		);

		mst_cell #(.WIDTH(CW), .INIT(DASH_INIT)) u_dash_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (dash_ctl),
			.prev   (dash_prev),
			.entry  (dash_row[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dit_total_q  <= DIT_TOTAL_INIT;
			dash_total_q <= DASH_TOTAL_INIT;
			dit_run_q    <= '0;
			dash_run_q   <= '0;
		end else if (acc) begin
			dit_total_q  <= dit_total_d;
			dash_total_q <= dash_total_d;
			dit_run_q    <= dit_run_d;
			dash_run_q   <= dash_run_d;
		end
	end

	mst_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc),
		.push_data (ref_time),
		.space     (space),
		.result    (result)
	);

endmodule
